// ----- rtl/core/iou_pkg.sv -----
// Package for the IoU detection matcher: sizes, command and register codes,
// rectangle and unit handshake types, state enums and the saturating increment.
// No dependencies.
package iou_pkg;

  localparam int MAX_TRUTH = 32;
  localparam int IDX_W     = $clog2(MAX_TRUTH);
  localparam int CNT_W     = $clog2(MAX_TRUTH + 1);

  localparam logic [2:0] CMD_START  = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_RAW    = 3'd2;
  localparam logic [2:0] CMD_GROUP  = 3'd3;
  localparam logic [2:0] CMD_REPORT = 3'd4;

  localparam logic [0:0] REG_SCORE   = 1'b0;
  localparam logic [0:0] REG_OVERLAP = 1'b1;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [12:0]        w;
    logic [12:0]        h;
  } box_t;

  typedef struct packed {
    logic        start;
    logic [16:0] thr;
    box_t        a;
    box_t        b;
  } eq_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic match;
  } eq_rsp_t;

  typedef enum logic [3:0] {
    U_IDLE, U_BOUND, U_INTER, U_AREA_A, U_AREA_B, U_UNION, U_LO, U_HI, U_CMP
  } ust_t;

  typedef enum logic [2:0] {
    T_IDLE, T_EXEC, T_FETCH, T_START, T_WAIT, T_FN, T_DONE
  } tst_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

endpackage

// ----- rtl/core/iou_if.sv -----
// Channel interfaces of the IoU detection matcher: input item, result item
// and configuration write. No dependencies.
interface iou_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [12:0] rect_x;
  logic signed [12:0] rect_y;
  logic [11:0]        rect_w;
  logic [11:0]        rect_h;
  logic signed [15:0] score;
  logic               confident;
  modport source (output valid, command, rect_x, rect_y, rect_w, rect_h, score, confident,
                  input ready);
  modport sink (input valid, command, rect_x, rect_y, rect_w, rect_h, score, confident,
                output ready);
endinterface

interface iou_out_if;
  logic        valid;
  logic        ready;
  logic        passed;
  logic        true_positive;
  logic [7:0]  matched_index;
  logic [15:0] tp_count;
  logic [15:0] fp_count;
  logic [15:0] fpw_count;
  logic [8:0]  fn_count;
  modport source (output valid, passed, true_positive, matched_index, tp_count, fp_count,
                  fpw_count, fn_count, input ready);
  modport sink (input valid, passed, true_positive, matched_index, tp_count, fp_count,
                fpw_count, fn_count, output ready);
endinterface

interface iou_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  addr;
  logic [16:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ----- rtl/core/iou_eq_unit.sv -----
// Shared rectangle equivalence unit: bounds, then one multiplier reused for
// intersection, areas and the threshold product. Depends on iou_pkg.
module iou_eq_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  iou_pkg::eq_req_t req,
  output iou_pkg::eq_rsp_t rsp
);
  import iou_pkg::*;

  ust_t st_r, st_nxt;
  box_t a_r, b_r;
  logic [16:0] thr_r;
  logic [12:0] dx_r, dy_r;
  logic [25:0] inter_r;
  logic [26:0] area_r, uni_r;
  logic [44:0] lhs_r;
  logic        done_r, match_r;

  logic signed [16:0] ar_x, br_x, ar_y, br_y, l_x, l_y, r_x, r_y, dx, dy;
  logic               overlap;
  logic [16:0]        mul_a;
  logic [13:0]        mul_b;
  logic [30:0]        prod;

  always_comb begin
    ar_x = 17'(a_r.x) + $signed({4'b0, a_r.w});
    br_x = 17'(b_r.x) + $signed({4'b0, b_r.w});
    ar_y = 17'(a_r.y) + $signed({4'b0, a_r.h});
    br_y = 17'(b_r.y) + $signed({4'b0, b_r.h});
    l_x  = (a_r.x > b_r.x) ? 17'(a_r.x) : 17'(b_r.x);
    l_y  = (a_r.y > b_r.y) ? 17'(a_r.y) : 17'(b_r.y);
    r_x  = (ar_x < br_x) ? ar_x : br_x;
    r_y  = (ar_y < br_y) ? ar_y : br_y;
    dx   = r_x - l_x;
    dy   = r_y - l_y;
    overlap = (dx > 17'sd1) && (dy > 17'sd1);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      U_INTER:  begin mul_a = {4'b0, dx_r};    mul_b = {1'b0, dy_r}; end
      U_AREA_A: begin mul_a = {4'b0, a_r.w};   mul_b = {1'b0, a_r.h}; end
      U_AREA_B: begin mul_a = {4'b0, b_r.w};   mul_b = {1'b0, b_r.h}; end
      U_LO:     begin mul_a = thr_r;           mul_b = uni_r[13:0]; end
      U_HI:     begin mul_a = thr_r;           mul_b = {1'b0, uni_r[26:14]}; end
      default:  begin mul_a = '0;              mul_b = '0; end
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      U_IDLE:   if (req.start) st_nxt = U_BOUND;
      U_BOUND:  st_nxt = overlap ? U_INTER : U_IDLE;
      U_INTER:  st_nxt = U_AREA_A;
      U_AREA_A: st_nxt = U_AREA_B;
      U_AREA_B: st_nxt = U_UNION;
      U_UNION:  st_nxt = U_LO;
      U_LO:     st_nxt = U_HI;
      U_HI:     st_nxt = U_CMP;
      U_CMP:    st_nxt = U_IDLE;
      default:  st_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= U_IDLE;
      done_r  <= 1'b0;
      match_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      done_r  <= 1'b0;
      if (st_r == U_BOUND && !overlap) begin
        done_r  <= 1'b1;
        match_r <= 1'b0;
      end else if (st_r == U_CMP) begin
        done_r  <= 1'b1;
        match_r <= (lhs_r <= {3'b0, inter_r, 16'b0});
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      U_IDLE: begin
        a_r   <= req.a;
        b_r   <= req.b;
        thr_r <= req.thr;
      end
      U_BOUND: begin
        dx_r <= dx[12:0];
        dy_r <= dy[12:0];
      end
      U_INTER:  inter_r <= prod[25:0];
      U_AREA_A: area_r <= prod[26:0];
      U_AREA_B: area_r <= area_r + prod[26:0];
      U_UNION:  uni_r <= area_r - {1'b0, inter_r};
      U_LO:     lhs_r <= {14'b0, prod};
      U_HI:     lhs_r <= lhs_r + {prod, 14'b0};
      default:  lhs_r <= lhs_r;
    endcase
  end

  assign rsp.busy  = (st_r != U_IDLE);
  assign rsp.done  = done_r;
  assign rsp.match = match_r;

endmodule

// ----- rtl/core/iou_detection_matcher_unit.sv -----
// Top level of the IoU detection matcher: command sequencer, truth store and
// event counters around the shared equivalence unit. Depends on iou_pkg, iou_if, iou_eq_unit.
//
// One result beat follows every input beat. A raw or grouped window scans the stored truths
// in order through one equivalence unit: each truth compared takes a store read, a unit
// start, up to eight unit steps and a decision. The scan ends when a match is found, and a
// grouped window skips truths already found. A report walks the stored truths once.
// The input is not ready while an item is at work; a finished result waits in its own
// register and the next item may be accepted meanwhile.
module iou_detection_matcher_unit (
  input  logic     clk,
  input  logic     rst_n,
  iou_in_if.sink   in_ch,
  iou_out_if.source out_ch,
  iou_cfg_if.sink  cfg_ch
);
  import iou_pkg::*;

  tst_t st_r, st_nxt;

  logic signed [15:0] score_thr_r;
  logic [16:0]        overlap_thr_r;

  logic [2:0]         cmd_r;
  box_t               item_r;
  logic signed [15:0] score_r;
  logic               conf_in_r;

  logic [CNT_W-1:0]   count_r, j_r, fn_r;
  logic [IDX_W-1:0]   idx_r;
  logic               passed_r, tp_r;
  logic [15:0]        tp_cnt_r, fp_cnt_r, fpw_cnt_r;
  logic [MAX_TRUTH-1:0] found_r;
  logic [MAX_TRUTH-1:0] conf_mem;
  box_t               raw_mem [MAX_TRUTH];
  box_t               norm_mem [MAX_TRUTH];
  box_t               rd_r;

  logic               out_valid_r;
  logic               out_passed_r, out_tp_r;
  logic [7:0]         out_idx_r;
  logic [15:0]        out_tp_cnt_r, out_fp_cnt_r, out_fpw_cnt_r;
  logic [8:0]         out_fn_r;

  eq_req_t            req;
  eq_rsp_t            rsp;

  logic               in_acc, out_load, pass, has_next, room;
  logic [12:0]        hh;
  logic [11:0]        nw;
  box_t               norm;

  iou_eq_unit u_eq (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  assign in_ch.ready  = (st_r == T_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_load = (st_r == T_DONE) && (!out_valid_r || out_ch.ready);
  assign pass     = (score_r >= score_thr_r);
  assign has_next = ((j_r + 1'b1) < count_r);
  assign room     = (count_r < CNT_W'(MAX_TRUTH));

  always_comb begin
    hh     = item_r.h + {2'b0, item_r.h[12:2]};
    nw     = hh[12:1];
    norm.x = item_r.x + $signed({4'b0, item_r.w[12:1]}) - $signed({5'b0, nw[11:1]});
    norm.y = item_r.y + $signed({4'b0, item_r.h[12:1]}) - $signed({4'b0, nw});
    norm.w = {1'b0, nw};
    norm.h = {nw, 1'b0};
  end

  always_comb begin
    req.start = (st_r == T_START);
    req.thr   = overlap_thr_r;
    req.a     = rd_r;
    req.b     = item_r;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      T_IDLE: if (in_acc) st_nxt = T_EXEC;
      T_EXEC: begin
        case (cmd_r)
          CMD_RAW:    st_nxt = (pass && count_r != '0) ? T_FETCH : T_DONE;
          CMD_GROUP:  st_nxt = (count_r != '0) ? T_FETCH : T_DONE;
          CMD_REPORT: st_nxt = (count_r != '0) ? T_FN : T_DONE;
          default:    st_nxt = T_DONE;
        endcase
      end
      T_FETCH: begin
        if (cmd_r == CMD_GROUP && found_r[j_r[IDX_W-1:0]]) begin
          st_nxt = has_next ? T_FETCH : T_DONE;
        end else begin
          st_nxt = T_START;
        end
      end
      T_START: st_nxt = T_WAIT;
      T_WAIT: begin
        if (rsp.done) begin
          st_nxt = (rsp.match || !has_next) ? T_DONE : T_FETCH;
        end
      end
      T_FN:   st_nxt = has_next ? T_FN : T_DONE;
      T_DONE: if (out_load) st_nxt = T_IDLE;
      default: st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= T_IDLE;
      score_thr_r   <= '0;
      overlap_thr_r <= 17'd32768;
      count_r       <= '0;
      found_r       <= '0;
      tp_cnt_r      <= '0;
      fp_cnt_r      <= '0;
      fpw_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.addr)
          REG_SCORE:   score_thr_r <= cfg_ch.data[15:0];
          REG_OVERLAP: overlap_thr_r <= cfg_ch.data;
          default:     overlap_thr_r <= overlap_thr_r;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        T_EXEC: begin
          case (cmd_r)
            CMD_START: begin
              count_r   <= '0;
              found_r   <= '0;
              tp_cnt_r  <= '0;
              fp_cnt_r  <= '0;
              fpw_cnt_r <= '0;
            end
            CMD_ADD: begin
              if (room) begin
                found_r[count_r[IDX_W-1:0]] <= 1'b0;
                count_r <= count_r + 1'b1;
              end
            end
            CMD_RAW:   if (pass && count_r == '0) fpw_cnt_r <= sat_inc(fpw_cnt_r);
            CMD_GROUP: if (count_r == '0) fp_cnt_r <= sat_inc(fp_cnt_r);
            default:   count_r <= count_r;
          endcase
        end
        T_FETCH: begin
          if (cmd_r == CMD_GROUP && found_r[j_r[IDX_W-1:0]] && !has_next) begin
            fp_cnt_r <= sat_inc(fp_cnt_r);
          end
        end
        T_WAIT: begin
          if (rsp.done) begin
            if (rsp.match) begin
              if (cmd_r == CMD_GROUP) begin
                found_r[j_r[IDX_W-1:0]] <= 1'b1;
                tp_cnt_r <= sat_inc(tp_cnt_r);
              end
            end else if (!has_next) begin
              if (cmd_r == CMD_GROUP) begin
                fp_cnt_r <= sat_inc(fp_cnt_r);
              end else begin
                fpw_cnt_r <= sat_inc(fpw_cnt_r);
              end
            end
          end
        end
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r     <= in_ch.command;
      item_r.x  <= 16'(in_ch.rect_x);
      item_r.y  <= 16'(in_ch.rect_y);
      item_r.w  <= {1'b0, in_ch.rect_w};
      item_r.h  <= {1'b0, in_ch.rect_h};
      score_r   <= in_ch.score;
      conf_in_r <= in_ch.confident;
    end
    case (st_r)
      T_EXEC: begin
        j_r      <= '0;
        fn_r     <= '0;
        idx_r    <= '0;
        tp_r     <= 1'b0;
        passed_r <= (cmd_r == CMD_RAW) && pass;
        if (cmd_r == CMD_ADD && room) begin
          raw_mem[count_r[IDX_W-1:0]]  <= item_r;
          norm_mem[count_r[IDX_W-1:0]] <= norm;
          conf_mem[count_r[IDX_W-1:0]] <= conf_in_r;
        end
      end
      T_FETCH: begin
        if (cmd_r == CMD_GROUP) begin
          rd_r <= norm_mem[j_r[IDX_W-1:0]];
          if (found_r[j_r[IDX_W-1:0]]) j_r <= j_r + 1'b1;
        end else begin
          rd_r <= raw_mem[j_r[IDX_W-1:0]];
        end
      end
      T_WAIT: begin
        if (rsp.done) begin
          if (rsp.match) begin
            tp_r <= 1'b1;
            if (cmd_r == CMD_GROUP) idx_r <= j_r[IDX_W-1:0];
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
      end
      T_FN: begin
        if (!found_r[j_r[IDX_W-1:0]] && conf_mem[j_r[IDX_W-1:0]]) fn_r <= fn_r + 1'b1;
        j_r <= j_r + 1'b1;
      end
      default: j_r <= j_r;
    endcase
    if (out_load) begin
      out_passed_r  <= passed_r;
      out_tp_r      <= tp_r;
      out_idx_r     <= 8'(idx_r);
      out_tp_cnt_r  <= tp_cnt_r;
      out_fp_cnt_r  <= fp_cnt_r;
      out_fpw_cnt_r <= fpw_cnt_r;
      out_fn_r      <= 9'(fn_r);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.passed        = out_passed_r;
  assign out_ch.true_positive = out_tp_r;
  assign out_ch.matched_index = out_idx_r;
  assign out_ch.tp_count      = out_tp_cnt_r;
  assign out_ch.fp_count      = out_fp_cnt_r;
  assign out_ch.fpw_count     = out_fpw_cnt_r;
  assign out_ch.fn_count      = out_fn_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TRUTH))
    else $error("truth count beyond table size");

  a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !rsp.busy)
    else $error("equivalence unit started while busy");

  a_claim_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && tp_r && !passed_r) |-> (9'(idx_r) < 9'(count_r)))
    else $error("claimed truth entry outside the table");

endmodule

// ----- tb/sv/iou_detection_matcher_unit_tb.sv -----
// Self-checking testbench for the IoU detection matcher top level.
// It drives command beats, predicts every result beat and compares them field by field.
// Depends on iou_pkg, the channel interfaces in iou_if and iou_detection_matcher_unit.
module iou_detection_matcher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iou_pkg::*;

  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [12:0] x;
    logic signed [12:0] y;
    logic [11:0]        w;
    logic [11:0]        h;
    logic signed [15:0] score;
    logic               conf;
  } cmd_item_t;

  typedef struct packed {
    logic        passed;
    logic        tp;
    logic [7:0]  idx;
    logic [15:0] tp_cnt;
    logic [15:0] fp_cnt;
    logic [15:0] fpw_cnt;
    logic [8:0]  fn_cnt;
  } match_res_t;

  typedef struct {
    int x, y, w, h;
  } rect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  iou_in_if  in_ch();
  iou_out_if out_ch();
  iou_cfg_if cfg_ch();

  iou_detection_matcher_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Matcher state as the testbench sees it.
  rect_t       gt_raw [MAX_TRUTH];
  rect_t       gt_norm [MAX_TRUTH];
  bit          gt_conf [MAX_TRUTH];
  bit          gt_found [MAX_TRUTH];
  int          gt_count;
  int unsigned ev_tp, ev_fp, ev_fpw;
  int          thr_score;
  longint      thr_overlap;

  cmd_item_t  cmd_queue[$];
  match_res_t expected_q[$];
  int errors, items_sent, results_seen, images, idle_cycles;
  int queued;
  int hold_left;
  bit hold_done;

  task automatic queue_cmd(cmd_item_t it);
    cmd_queue = {cmd_queue, it};
    queued++;
  endtask

  function automatic rect_t norm_rect(rect_t r);
    rect_t n;
    int cx, cy, nw;
    cx = r.x + r.w / 2;
    cy = r.y + r.h / 2;
    nw = ((r.h * 5) / 4) / 2;
    n.x = cx - nw / 2;
    n.y = cy - nw;
    n.w = nw;
    n.h = 2 * nw;
    return n;
  endfunction

  function automatic bit overlaps(rect_t a, rect_t b);
    int ix1, iy1, ix2, iy2;
    longint inter, uni;
    ix1 = (a.x > b.x) ? a.x : b.x;
    iy1 = (a.y > b.y) ? a.y : b.y;
    ix2 = ((a.x + a.w < b.x + b.w) ? a.x + a.w : b.x + b.w) - 1;
    iy2 = ((a.y + a.h < b.y + b.h) ? a.y + a.h : b.y + b.h) - 1;
    if (ix2 <= ix1 || iy2 <= iy1) return 1'b0;
    inter = longint'(ix2 - ix1 + 1) * longint'(iy2 - iy1 + 1);
    uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
    return thr_overlap * uni <= inter * 65536;
  endfunction

  function automatic int unsigned sat_bump(int unsigned v);
    return (v < 65535) ? v + 1 : v;
  endfunction

  task automatic predict_match(cmd_item_t it);
    match_res_t r;
    rect_t box;
    r = '0;
    box.x = it.x;
    box.y = it.y;
    box.w = it.w;
    box.h = it.h;
    case (it.cmd)
      CMD_START: begin
        gt_count = 0;
        foreach (gt_found[j]) gt_found[j] = 1'b0;
        ev_tp = 0;
        ev_fp = 0;
        ev_fpw = 0;
      end
      CMD_ADD: begin
        if (gt_count < MAX_TRUTH) begin
          gt_raw[gt_count] = box;
          gt_norm[gt_count] = norm_rect(box);
          gt_conf[gt_count] = it.conf;
          gt_found[gt_count] = 1'b0;
          gt_count++;
        end
      end
      CMD_RAW: begin
        if (int'(it.score) >= thr_score) begin
          r.passed = 1'b1;
          for (int j = 0; j < gt_count; j++) begin
            if (overlaps(gt_raw[j], box)) begin
              r.tp = 1'b1;
              break;
            end
          end
          if (!r.tp) ev_fpw = sat_bump(ev_fpw);
        end
      end
      CMD_GROUP: begin
        for (int j = 0; j < gt_count; j++) begin
          if (!gt_found[j] && overlaps(gt_norm[j], box)) begin
            gt_found[j] = 1'b1;
            r.tp = 1'b1;
            r.idx = j[7:0];
            break;
          end
        end
        if (r.tp) ev_tp = sat_bump(ev_tp);
        else ev_fp = sat_bump(ev_fp);
      end
      CMD_REPORT: begin
        for (int j = 0; j < gt_count; j++)
          if (!gt_found[j] && gt_conf[j]) r.fn_cnt++;
      end
      default: ;
    endcase
    r.tp_cnt = ev_tp[15:0];
    r.fp_cnt = ev_fp[15:0];
    r.fpw_cnt = ev_fpw[15:0];
    expected_q = {expected_q, r};
  endtask

  // Sender: one beat per queued command, with a random gap after each.
  int  send_gap;
  bit  send_calm;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_match(cmd_queue.pop_front());
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          in_ch.valid     <= 1'b1;
          in_ch.command   <= cmd_queue[0].cmd;
          in_ch.rect_x    <= cmd_queue[0].x;
          in_ch.rect_y    <= cmd_queue[0].y;
          in_ch.rect_w    <= cmd_queue[0].w;
          in_ch.rect_h    <= cmd_queue[0].h;
          in_ch.score     <= cmd_queue[0].score;
          in_ch.confident <= cmd_queue[0].conf;
          items_sent++;
          if ($urandom_range(0, 31) == 0) send_calm = ~send_calm;
          send_gap = send_calm ? 0 : $urandom_range(0, 16);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Receiver: checks each result beat against the oldest prediction.
  int  recv_gap;
  bit  recv_calm;
  match_res_t exp_r;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with no prediction waiting", $time);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("passed", exp_r.passed, out_ch.passed);
          check_field("true_positive", exp_r.tp, out_ch.true_positive);
          check_field("matched_index", exp_r.idx, out_ch.matched_index);
          check_field("tp_count", exp_r.tp_cnt, out_ch.tp_count);
          check_field("fp_count", exp_r.fp_cnt, out_ch.fp_count);
          check_field("fpw_count", exp_r.fpw_cnt, out_ch.fpw_count);
          check_field("fn_count", exp_r.fn_cnt, out_ch.fn_count);
        end
        if ($urandom_range(0, 31) == 0) recv_calm = ~recv_calm;
        recv_gap = recv_calm ? 0 : $urandom_range(0, 16);
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Long receiver stall once, while the sender keeps offering beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && items_sent >= 300) begin
      hold_done <= 1'b1;
      hold_left <= 600;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic signed [12:0] coord(int v);
    if (v > 4095) return 13'sd4095;
    if (v < -4096) return -13'sd4096;
    return v[12:0];
  endfunction

  function automatic logic [11:0] extent(int v);
    if (v > 4095) return 12'd4095;
    if (v < 0) return 12'd0;
    return v[11:0];
  endfunction

  function automatic cmd_item_t make_item(logic [2:0] c, int x, int y, int w, int h,
                                          int s, bit cf);
    cmd_item_t it;
    it.cmd = c;
    it.x = coord(x);
    it.y = coord(y);
    it.w = extent(w);
    it.h = extent(h);
    it.score = s[15:0];
    it.conf = cf;
    return it;
  endfunction

  function automatic cmd_item_t noise_item();
    cmd_item_t it;
    it.cmd = 3'($urandom_range(0, 7));
    it.x = 13'($urandom);
    it.y = 13'($urandom);
    it.w = 12'($urandom);
    it.h = 12'($urandom);
    it.score = 16'($urandom);
    it.conf = 1'($urandom);
    return it;
  endfunction

  function automatic int jitter(int v, int span);
    return v + $urandom_range(0, 2 * span) - span;
  endfunction

  // One image: start, a set of truths, windows near and away from them, noise, interim reports, final report.
  task automatic queue_image();
    rect_t tr[$];
    rect_t t, n;
    int nt, nw, span, sc;
    nt = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_TRUTH - 2, MAX_TRUTH + 3)
                                     : $urandom_range(0, 6);
    nw = $urandom_range(2, 12);
    queue_cmd(make_item(CMD_START, $urandom, $urandom, $urandom, $urandom,
                        $urandom, 1'($urandom)));
    for (int i = 0; i < nt; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        t.x = $signed(13'($urandom));
        t.y = $signed(13'($urandom));
        t.w = $urandom_range(0, 4095);
        t.h = $urandom_range(0, 4095);
      end else begin
        t.x = $urandom_range(0, 1200) - 200;
        t.y = $urandom_range(0, 1200) - 200;
        t.w = $urandom_range(1, 160);
        t.h = $urandom_range(1, 160);
      end
      tr = {tr, t};
      queue_cmd(make_item(CMD_ADD, t.x, t.y, t.w, t.h, $urandom, 1'($urandom)));
    end
    for (int i = 0; i < nw; i++) begin
      sc = ($urandom_range(0, 1) == 0) ? int'($urandom) : thr_score + $urandom_range(0, 64) - 8;
      if (sc > 32767) sc = 32767;
      if (tr.size() > 0) t = tr[$urandom_range(0, tr.size() - 1)];
      else begin
        t.x = 0;
        t.y = 0;
        t.w = 20;
        t.h = 20;
      end
      span = (t.w + t.h) / 16 + 1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: queue_cmd(make_item(CMD_RAW, jitter(t.x, span),
                      jitter(t.y, span), jitter(t.w, span), jitter(t.h, span), sc, 0));
        4, 5, 6, 7: begin
          n = norm_rect(t);
          queue_cmd(make_item(CMD_GROUP, jitter(n.x, span), jitter(n.y, span),
                    jitter(n.w, span), jitter(n.h, span), $urandom, 1'($urandom)));
        end
        8: queue_cmd(make_item(($urandom_range(0, 1) ? CMD_RAW : CMD_GROUP),
                     $urandom_range(0, 2000) - 500, $urandom_range(0, 2000) - 500,
                     $urandom_range(0, 300), $urandom_range(0, 300), sc, 0));
        default: queue_cmd(noise_item());
      endcase
      if ($urandom_range(0, 5) == 0) queue_cmd(make_item(CMD_REPORT, $urandom,
                                      $urandom, $urandom, $urandom, $urandom, 1'($urandom)));
    end
    queue_cmd(make_item(CMD_REPORT, 0, 0, 0, 0, 0, 0));
    images++;
  endtask

  task automatic wait_idle();
    while (cmd_queue.size() > 0 || expected_q.size() > 0 || in_ch.valid) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(logic [0:0] addr, logic [16:0] data);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= addr;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    if (addr == REG_SCORE) thr_score = $signed(data[15:0]);
    else thr_overlap = data;
  endtask

  task automatic random_phase(logic [16:0] sc, logic [16:0] ov, int n_items);
    int target;
    wait_idle();
    cfg_write(REG_SCORE, sc);
    cfg_write(REG_OVERLAP, ov);
    target = queued + n_items;
    while (queued < target) queue_image();
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = REG_SCORE;
    cfg_ch.data = '0;
    thr_score = 0;
    thr_overlap = 32768;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every command, border overlap, found truths, unused codes.
    queue_cmd(make_item(CMD_START, 0, 0, 0, 0, 0, 0));
    queue_cmd(make_item(CMD_ADD, -4096, -4096, 4095, 4095, 0, 1));
    queue_cmd(make_item(CMD_ADD, 4095, 4095, 0, 0, 0, 1));
    queue_cmd(make_item(CMD_ADD, 0, 0, 10, 10, 0, 0));
    queue_cmd(make_item(CMD_ADD, 100, 100, 40, 80, 0, 1));
    queue_cmd(make_item(CMD_RAW, 0, 0, 10, 10, 32767, 0));
    queue_cmd(make_item(CMD_RAW, 0, 0, 10, 10, -32768, 0));
    queue_cmd(make_item(CMD_RAW, 9, 0, 10, 10, 0, 0));
    queue_cmd(make_item(CMD_RAW, 2000, 2000, 5, 5, 1, 0));
    queue_cmd(make_item(CMD_GROUP, 110, 90, 50, 100, 0, 0));
    queue_cmd(make_item(CMD_GROUP, 110, 90, 50, 100, 0, 0));
    queue_cmd(make_item(CMD_GROUP, -4096, -4096, 4095, 4095, 0, 0));
    queue_cmd(make_item(CMD_REPORT, 0, 0, 0, 0, 0, 0));
    queue_cmd(make_item(3'd5, 1, 1, 1, 1, 1, 1));
    queue_cmd(make_item(3'd6, -1, -1, 4095, 4095, -1, 1));
    queue_cmd(make_item(3'd7, 0, 0, 0, 0, 0, 0));
    queue_cmd(make_item(CMD_START, 0, 0, 0, 0, 0, 0));
    queue_cmd(make_item(CMD_REPORT, 0, 0, 0, 0, 0, 0));

    random_phase(17'd0, 17'd32768, 300);
    random_phase(17'h18000, 17'd0, 250);
    random_phase(17'h07FFF, 17'd65536, 250);
    random_phase(17'($urandom), 17'd65537, 150);
    random_phase(17'($urandom_range(0, 512) - 256), 17'd131071, 150);
    random_phase(17'($urandom), 17'($urandom_range(20000, 65536)), 300);
    random_phase(17'h1FF00, 17'($urandom_range(0, 65536)), 250);
    wait_idle();

    repeat (50) @(posedge clk);
    if (expected_q.size() > 0) begin
      $display("%0t: %0d predicted results never arrived", $time, expected_q.size());
      errors++;
    end
    $display("Run covered %0d command beats over %0d random images and seven threshold settings,",
             items_sent, images);
    $display("with %0d result beats checked and %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
